@@ rtl/nnis_pkg.sv @@
// Shared types and constants of the nearest-neighbour image scaler.
// Used by the controller, the datapath and the top level; depends on nothing.
package nnis_pkg;

  localparam int CFG_W = 10;
  localparam int PIX_W = 8;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
  localparam logic [IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

  localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = 10'd256;
  localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = 10'd256;
  localparam logic [CFG_W-1:0] RST_TARGET_WIDTH  = 10'd300;
  localparam logic [CFG_W-1:0] RST_TARGET_HEIGHT = 10'd300;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_COL_START,
    ST_COL_WAIT,
    ST_ROW_START,
    ST_ROW_WAIT,
    ST_RUN
  } nnis_state_t;

  typedef struct packed {
    logic div_start;
    logic div_row;
    logic cap_col;
    logic cap_row;
    logic run;
  } nnis_cmd_t;

  typedef struct packed {
    logic div_done;
  } nnis_sts_t;

endpackage

@@ rtl/nnis_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Used by the datapath for the scale steps; depends on no other file.
module nnis_div #(
  parameter int W = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     divisor;
  logic [W-1:0]     shreg;
  logic [W-1:0]     part;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [W:0]       trial;
  logic             fits;

  always_comb begin
    trial = {part, shreg[W-1]};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= den;
      shreg   <= num;
      part    <= '0;
    end else if (busy) begin
      shreg <= {shreg[W-2:0], fits};
      if (fits) begin
        part <= W'(trial - {1'b0, divisor});
      end else begin
        part <= trial[W-1:0];
      end
    end
  end

  assign quo = shreg;
  assign rem = part;

endmodule

@@ rtl/nnis_datapath.sv @@
// Datapath: size registers, frame store, load and output scan counters,
// exact quotient/remainder accumulators. Depends on nnis_pkg and nnis_div.
module nnis_datapath #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [nnis_pkg::IDX_W-1:0]   cfg_index,
  input  logic [nnis_pkg::CFG_W-1:0]   cfg_data,
  input  nnis_pkg::nnis_cmd_t          cmd,
  output nnis_pkg::nnis_sts_t          sts,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [nnis_pkg::PIX_W-1:0]   s_axis_tdata,
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [nnis_pkg::PIX_W-1:0]   m_axis_tdata,
  output logic                         m_axis_tlast,
  output logic                         m_axis_tuser
);

  import nnis_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int XLW   = (XW > CFG_W) ? XW : CFG_W;
  localparam int YLW   = (YW > CFG_W) ? YW : CFG_W;

  logic [CFG_W-1:0] source_width, source_height, target_width, target_height;
  logic [CFG_W-1:0] sw, sh, tw, th;

  logic [PIX_W-1:0] mem [DEPTH];

  logic [XW-1:0]    load_column;
  logic [YW-1:0]    load_row;
  logic [XW-1:0]    out_column;
  logic [YW-1:0]    out_row;
  logic [CFG_W-1:0] col_q, col_r, row_q, row_r;
  logic [CFG_W-1:0] col_step_q, col_step_r, row_step_q, row_step_r;
  logic [XW-1:0]    src_x;
  logic [YW-1:0]    src_y;

  logic [CFG_W-1:0] div_quo, div_rem;
  logic             div_done;

  logic             in_acc, load_acc, emit_acc;
  logic             load_col_last, load_row_last;
  logic             row_end, frame_end;
  logic [AW-1:0]    wr_addr, rd_addr;

  logic [CFG_W:0]   col_sum, row_sum;
  logic             col_wrap, row_wrap;
  logic [CFG_W-1:0] col_q_next, col_r_next, row_q_next, row_r_next;
  logic [CFG_W-1:0] col_idx, row_idx;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v, input int maxv);
    logic [CFG_W-1:0] res;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (32'(v) > maxv) begin
      res = CFG_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // round q + r/den to nearest, ties to even, clamped to limit-1
  function automatic logic [CFG_W-1:0] round_idx(input logic [CFG_W-1:0] q,
                                                 input logic [CFG_W-1:0] r,
                                                 input logic [CFG_W-1:0] den,
                                                 input logic [CFG_W-1:0] limit);
    logic [CFG_W:0]   twice;
    logic [CFG_W-1:0] res;
    twice = {r, 1'b0};
    res   = q;
    if (twice > {1'b0, den} || (twice == {1'b0, den} && q[0])) begin
      res = q + 1'b1;
    end
    if (res > limit - 1'b1) begin
      res = limit - 1'b1;
    end
    return res;
  endfunction

  assign sw = clamp_size(source_width, MAX_WIDTH);
  assign sh = clamp_size(source_height, MAX_HEIGHT);
  assign tw = clamp_size(target_width, MAX_WIDTH);
  assign th = clamp_size(target_height, MAX_HEIGHT);

  nnis_div #(.W(CFG_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (cmd.div_row ? sh : sw),
    .den   (cmd.div_row ? th : tw),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign sts.div_done = div_done;

  assign s_axis_tready = cmd.run && (!m_axis_tvalid || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load_acc      = in_acc && (s_axis_tuser == FUNC_LOAD);
  assign emit_acc      = in_acc && (s_axis_tuser == FUNC_EMIT);

  assign load_col_last = XLW'(load_column) == XLW'(sw - 1'b1);
  assign load_row_last = YLW'(load_row) == YLW'(sh - 1'b1);
  assign row_end       = XLW'(out_column) == XLW'(tw - 1'b1);
  assign frame_end     = row_end && (YLW'(out_row) == YLW'(th - 1'b1));

  assign wr_addr = AW'(load_row) * AW'(MAX_WIDTH) + AW'(load_column);
  assign rd_addr = AW'(src_y) * AW'(MAX_WIDTH) + AW'(src_x);

  always_comb begin
    col_sum    = {1'b0, col_r} + {1'b0, col_step_r};
    col_wrap   = col_sum >= {1'b0, tw};
    col_r_next = col_wrap ? CFG_W'(col_sum - {1'b0, tw}) : col_sum[CFG_W-1:0];
    col_q_next = col_q + col_step_q + CFG_W'(col_wrap);
    col_idx    = round_idx(col_q_next, col_r_next, tw, sw);
    row_sum    = {1'b0, row_r} + {1'b0, row_step_r};
    row_wrap   = row_sum >= {1'b0, th};
    row_r_next = row_wrap ? CFG_W'(row_sum - {1'b0, th}) : row_sum[CFG_W-1:0];
    row_q_next = row_q + row_step_q + CFG_W'(row_wrap);
    row_idx    = round_idx(row_q_next, row_r_next, th, sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= RST_SOURCE_WIDTH;
      source_height <= RST_SOURCE_HEIGHT;
      target_width  <= RST_TARGET_WIDTH;
      target_height <= RST_TARGET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        REG_TARGET_WIDTH:  target_width  <= cfg_data;
        REG_TARGET_HEIGHT: target_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_col) begin
      col_step_q <= div_quo;
      col_step_r <= div_rem;
    end
    if (cmd.cap_row) begin
      row_step_q <= div_quo;
      row_step_r <= div_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      load_column <= '0;
      load_row    <= '0;
    end else if (load_acc) begin
      if (load_col_last) begin
        load_column <= '0;
        load_row    <= load_row_last ? '0 : load_row + 1'b1;
      end else begin
        load_column <= load_column + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      out_column <= '0;
      out_row    <= '0;
      col_q      <= '0;
      col_r      <= '0;
      row_q      <= '0;
      row_r      <= '0;
      src_x      <= '0;
      src_y      <= '0;
    end else if (emit_acc) begin
      if (row_end) begin
        out_column <= '0;
        col_q      <= '0;
        col_r      <= '0;
        src_x      <= '0;
        if (frame_end) begin
          out_row <= '0;
          row_q   <= '0;
          row_r   <= '0;
          src_y   <= '0;
        end else begin
          out_row <= out_row + 1'b1;
          row_q   <= row_q_next;
          row_r   <= row_r_next;
          src_y   <= YW'(row_idx);
        end
      end else begin
        out_column <= out_column + 1'b1;
        col_q      <= col_q_next;
        col_r      <= col_r_next;
        src_x      <= XW'(col_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_acc) begin
      mem[wr_addr] <= s_axis_tdata;
    end
    if (emit_acc) begin
      m_axis_tdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (emit_acc) begin
      m_axis_tlast <= row_end;
      m_axis_tuser <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_acc) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

@@ rtl/nnis_ctrl.sv @@
// Controller: sequences the two scale-step divisions after reset or a
// register write, then enables streaming. Depends on nnis_pkg.
module nnis_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  nnis_pkg::nnis_sts_t sts,
  output nnis_pkg::nnis_cmd_t cmd
);

  import nnis_pkg::*;

  nnis_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COL_START;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    if (cfg_we) begin
      state_next = ST_COL_START;
    end else begin
      case (state)
        ST_COL_START: state_next = ST_COL_WAIT;
        ST_COL_WAIT:  if (sts.div_done) state_next = ST_ROW_START;
        ST_ROW_START: state_next = ST_ROW_WAIT;
        ST_ROW_WAIT:  if (sts.div_done) state_next = ST_RUN;
        ST_RUN:       state_next = ST_RUN;
        default:      state_next = ST_COL_START;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_COL_START: cmd.div_start = 1'b1;
      ST_COL_WAIT:  cmd.cap_col   = sts.div_done;
      ST_ROW_START: begin
        cmd.div_start = 1'b1;
        cmd.div_row   = 1'b1;
      end
      ST_ROW_WAIT: begin
        cmd.div_row = 1'b1;
        cmd.cap_row = sts.div_done;
      end
      ST_RUN:       cmd.run = 1'b1;
      default:      cmd = '0;
    endcase
  end

endmodule

@@ rtl/nearest_neighbor_image_scaler_core.sv @@
// Top level of the nearest-neighbour grayscale image scaler.
// Depends on nnis_pkg, nnis_ctrl, nnis_datapath and nnis_div.
//
// Input stream: each word carries tuser = 0 to load one source pixel (tdata)
// into the frame store in raster order, or tuser = 1 to request the next
// destination pixel in raster order. Output stream: one word per request,
// tdata = grey value, tlast = last pixel of the destination row,
// tuser = last pixel of the destination frame. Loads produce no output.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 source width, 1 source height, 2 target width, 3 target height);
// any write restarts both scans at the origin.
// Throughput is one word per cycle on the input; a request's pixel is shown
// on the output in the cycle after it is accepted (registered frame store
// read). When the receiver stalls, the output word holds and the input
// stops accepting until it is taken.
// After reset and after each register write the column and row scale steps
// are found one after the other by a shared bit-serial divider, during which
// s_axis_tready stays low. The frame store is not cleared; only loaded
// pixels may be requested.
module nearest_neighbor_image_scaler_core #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [nnis_pkg::IDX_W-1:0]   cfg_index,
  input  logic [nnis_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [nnis_pkg::PIX_W-1:0]   s_axis_tdata,   // [7:0] pixel_in
  input  logic                         s_axis_tuser,   // [0] func
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [nnis_pkg::PIX_W-1:0]   m_axis_tdata,   // [7:0] pixel_out
  output logic                         m_axis_tlast,   // row_end
  output logic                         m_axis_tuser    // [0] frame_end
);

  import nnis_pkg::*;

  nnis_cmd_t cmd;
  nnis_sts_t sts;

  nnis_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg_we (cfg_we),
    .sts    (sts),
    .cmd    (cmd)
  );

  nnis_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
